// ===== sv/itwre_pkg.sv =====
// ----------------------------------------------------------------------------
// itwre_pkg
// Shared types and constants of the index-to-word expander.
// ----------------------------------------------------------------------------
package itwre_pkg;

   // default sizes
   localparam int MAX_CHARS_DEF = 64;
   localparam int MAX_LEN_DEF   = 16;

   // fixed field widths
   localparam int INDEX_W = 63;
   localparam int DIGIT_W = 7;
   localparam int LENGTH_W = 5;
   localparam int CHAR_W  = 8;
   localparam int POS_W   = 6;
   localparam int OUT_POS_W = 4;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W = 7;
   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 16;

   // request kinds carried on tuser
   localparam logic FUNC_LOAD    = 1'b0;
   localparam logic FUNC_CONVERT = 1'b1;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_CHARSET_SIZE = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WORD_LENGTH  = 1'b1;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_DIVIDE,
      SEQ_READ,
      SEQ_PUSH
   } seq_state_type;

   typedef struct packed {
      logic                 done;
      logic [DIGIT_W-1:0]   remainder;
      logic [INDEX_W-1:0]   quotient;
   } div_result_type;

endpackage

// ===== sv/index_to_word_radix_expand.sv =====
// ----------------------------------------------------------------------------
// index_to_word_radix_expand
// Turns a word index into charset characters by repeated division by the
// charset size; a load word writes one charset table entry.
//
//   channel  dir  handshake             payload
//   req      in   req_tvalid/tready     tuser: func; tdata: char_pos, char_value,
//                                       word_index
//   rsp      out  rsp_tvalid/tready     tdata: out_char, out_pos; tlast: last
//   csr      in   csr_we                csr_index, csr_wdata
//
// A load word writes one table entry as it is accepted. A convert word runs each
// character through 63 divider steps, done, table read and output load,
// using the bit-serial divider, which is shared by all characters of the word.
// The output register lets the next character's division run while a result
// waits; a stalled rsp side holds the sequencer only when that register is full.
// Reset is synchronous; it clears the sequencer and output valid and sets both csr registers to one.
// ----------------------------------------------------------------------------
module index_to_word_radix_expand #(
   parameter int MAX_CHARS = itwre_pkg::MAX_CHARS_DEF,
   parameter int MAX_LEN   = itwre_pkg::MAX_LEN_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // char_pos [5:0], char_value [13:6], word_index [76:14], zero fill
   input  logic [itwre_pkg::REQ_DATA_W-1:0]     req_tdata,
   // func [0]
   input  logic                                 req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // out_char [7:0], out_pos [11:8], zero fill
   output logic [itwre_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                 rsp_tlast,
   input  logic                                 csr_we,
   input  logic [itwre_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [itwre_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int ADDR_W = $clog2(MAX_CHARS);
   localparam int LEN_W  = $clog2(MAX_LEN + 1);
   localparam int PW     = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

   itwre_pkg::seq_state_type state_ff, state_in;

   logic [itwre_pkg::DIGIT_W-1:0]  size_ff;
   logic [itwre_pkg::LENGTH_W-1:0] length_ff;
   logic [PW-1:0]                  pos_ff, pos_in;

   logic                           rsp_valid_ff;
   logic [itwre_pkg::CHAR_W-1:0]   rsp_char_ff;
   logic [itwre_pkg::OUT_POS_W-1:0] rsp_pos_ff;
   logic                           rsp_last_ff;

   logic [itwre_pkg::POS_W-1:0]    char_pos;
   logic [itwre_pkg::CHAR_W-1:0]   char_value;
   logic [itwre_pkg::INDEX_W-1:0]  word_index;

   logic [itwre_pkg::DIGIT_W-1:0]  radix;
   logic [LEN_W-1:0]               length;
   logic                           req_fire;
   logic                           out_free;
   logic                           div_start;
   logic [itwre_pkg::INDEX_W-1:0]  dividend;
   itwre_pkg::div_result_type      div_res;
   logic                           wr_en;
   logic                           rd_en;
   logic                           load_out;
   logic [itwre_pkg::CHAR_W-1:0]   rd_data;

   assign char_pos   = req_tdata[5:0];
   assign char_value = req_tdata[13:6];
   assign word_index = req_tdata[76:14];

   // radix zero acts as one, radix and length saturate at the table sizes
   always_comb begin
      if (size_ff == '0) begin
         radix = itwre_pkg::DIGIT_W'(1);
      end else if (int'(size_ff) > MAX_CHARS) begin
         radix = itwre_pkg::DIGIT_W'(MAX_CHARS);
      end else begin
         radix = size_ff;
      end
      if (int'(length_ff) > MAX_LEN) begin
         length = LEN_W'(MAX_LEN);
      end else begin
         length = LEN_W'(length_ff);
      end
   end

   assign req_tready = (state_ff == itwre_pkg::SEQ_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign dividend   = (state_ff == itwre_pkg::SEQ_IDLE) ? word_index : div_res.quotient;

   always_comb begin
      state_in  = state_ff;
      pos_in    = pos_ff;
      div_start = 1'b0;
      wr_en     = 1'b0;
      rd_en     = 1'b0;
      load_out  = 1'b0;
      unique case (state_ff)
         itwre_pkg::SEQ_IDLE: begin
            if (req_fire) begin
               if (req_tuser == itwre_pkg::FUNC_LOAD) begin
                  wr_en = int'(char_pos) < MAX_CHARS;
               end else if (length != '0) begin
                  div_start = 1'b1;
                  pos_in    = PW'(length - 1'b1);
                  state_in  = itwre_pkg::SEQ_DIVIDE;
               end
            end
         end
         itwre_pkg::SEQ_DIVIDE: begin
            if (div_res.done) begin
               state_in = itwre_pkg::SEQ_READ;
            end
         end
         itwre_pkg::SEQ_READ: begin
            rd_en    = 1'b1;
            state_in = itwre_pkg::SEQ_PUSH;
         end
         itwre_pkg::SEQ_PUSH: begin
            // wait for a free output slot, then start on the next digit, or go idle after the last
            if (out_free) begin
               load_out = 1'b1;
               if (pos_ff == '0) begin
                  state_in = itwre_pkg::SEQ_IDLE;
               end else begin
                  pos_in    = pos_ff - 1'b1;
                  div_start = 1'b1;
                  state_in  = itwre_pkg::SEQ_DIVIDE;
               end
            end
         end
         default: begin
            state_in = itwre_pkg::SEQ_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= itwre_pkg::SEQ_IDLE;
         size_ff   <= itwre_pkg::DIGIT_W'(1);
         length_ff <= itwre_pkg::LENGTH_W'(1);
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            unique case (csr_index)
               itwre_pkg::CSR_CHARSET_SIZE: size_ff <= csr_wdata;
               itwre_pkg::CSR_WORD_LENGTH:
                  length_ff <= csr_wdata[itwre_pkg::LENGTH_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      if (load_out) begin
         rsp_char_ff <= rd_data;
         rsp_pos_ff  <= itwre_pkg::OUT_POS_W'(pos_ff);
         rsp_last_ff <= (pos_ff == '0);
      end
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   itwre_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (radix),
      .result   (div_res)
   );

   itwre_charset #(
      .DEPTH  (MAX_CHARS),
      .ADDR_W (ADDR_W)
   ) u_charset (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (ADDR_W'(char_pos)),
      .wr_data (char_value),
      .rd_en   (rd_en),
      .rd_addr (ADDR_W'(div_res.remainder)),
      .rd_data (rd_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(itwre_pkg::RSP_DATA_W - itwre_pkg::OUT_POS_W
                          - itwre_pkg::CHAR_W){1'b0}}, rsp_pos_ff, rsp_char_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== sv/itwre_divider.sv =====
// ----------------------------------------------------------------------------
// itwre_divider
// Restoring divider, one quotient bit per cycle, 63-bit index by a 7-bit radix.
// ----------------------------------------------------------------------------
module itwre_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [itwre_pkg::INDEX_W-1:0] dividend,
   input  logic [itwre_pkg::DIGIT_W-1:0] divisor,
   output itwre_pkg::div_result_type     result
);

   localparam int CNT_W = $clog2(itwre_pkg::INDEX_W);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(itwre_pkg::INDEX_W - 1);

   logic [itwre_pkg::INDEX_W-1:0] work_ff, work_in;
   logic [itwre_pkg::DIGIT_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [itwre_pkg::DIGIT_W:0]   shifted;
   logic                          fits;

   assign shifted = {rem_ff, work_ff[itwre_pkg::INDEX_W-1]};
   assign fits    = shifted >= {1'b0, divisor};

   always_comb begin
      work_in  = work_ff;
      rem_in   = rem_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         work_in  = dividend;
         rem_in   = '0;
         count_in = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         // shift the next dividend bit into the remainder, quotient bit in at the bottom
         work_in  = {work_ff[itwre_pkg::INDEX_W-2:0], fits};
         rem_in   = fits ? itwre_pkg::DIGIT_W'(shifted - {1'b0, divisor})
                         : shifted[itwre_pkg::DIGIT_W-1:0];
         count_in = count_ff + 1'b1;
         if (count_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      work_ff  <= work_in;
      rem_ff   <= rem_in;
      count_ff <= count_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign result.done      = done_ff;
   assign result.remainder = rem_ff;
   assign result.quotient  = work_ff;

endmodule

// ===== sv/itwre_charset.sv =====
// ----------------------------------------------------------------------------
// itwre_charset
// Charset table: one write port, one registered read port.
// ----------------------------------------------------------------------------
module itwre_charset #(
   parameter int DEPTH  = itwre_pkg::MAX_CHARS_DEF,
   parameter int ADDR_W = $clog2(itwre_pkg::MAX_CHARS_DEF)
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [ADDR_W-1:0]            wr_addr,
   input  logic [itwre_pkg::CHAR_W-1:0] wr_data,
   input  logic                         rd_en,
   input  logic [ADDR_W-1:0]            rd_addr,
   output logic [itwre_pkg::CHAR_W-1:0] rd_data
);

   logic [itwre_pkg::CHAR_W-1:0] mem [DEPTH];
   logic [itwre_pkg::CHAR_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      // hold the read word until the next read
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
